FILE: rtl/hrlp_pkg.sv
package hrlp_pkg;

	localparam logic [7:0] ACK_CODE = 8'h06;
	localparam logic [7:0] NAK_CODE = 8'h15;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] TIMEOUT_RESET = 8'd200;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF = 8'h01;
	localparam logic [7:0] REC_EXT_LIN = 8'h04;

	localparam int RESULT_BITS = 69;
	localparam int TDATA_OUT_BITS = 72;

	// Declared from the highest field down, so tx_count sits in the lowest bits.
	typedef struct packed {
		logic [7:0]  command_code;
		logic        command_valid;
		logic        write_half;
		logic [31:0] write_addr;
		logic        write_valid;
		logic [7:0]  data_value;
		logic [5:0]  data_index;
		logic        data_half;
		logic        data_valid;
		logic [7:0]  tx_byte;
		logic [1:0]  tx_count;
	} result_t;

	// Letters from 'A' up map to ten and above; anything else is taken as a decimal digit.
	function automatic logic [7:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CHAR_UPPER_A) begin
			v = c - CHAR_UPPER_A + 8'd10;
		end else begin
			v = c - CHAR_ZERO;
		end
		return v;
	endfunction

endpackage

FILE: rtl/hex_record_loader_parser.sv
// Channel  Direction  Handshake                 Payload
// s        in         s_tvalid / s_tready       s_tdata[7:0] char_in, s_tuser[0] mode
// m        out        m_tvalid / m_tready       m_tdata[68:0] result fields, zero padded
// cfg      in         cfg_wr_en (no wait)       cfg_wr_data[7:0] timeout_limit
//
// Every input transaction produces exactly one output transaction, via the input and result registers.
// One transaction a cycle is sustained while m_tready is high; the parse state update is combinational.
// arst_n clears the parser state, both stage valids and sets timeout_limit to 200.
// A stalled output holds the result register; the input register still refills as soon
// as its item moves on, so at most two items are held inside.
module hex_record_loader_parser #(
	parameter int BLOCK_BYTES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,     // [7:0] char_in
	input  logic [0:0]                           s_tuser,     // [0] mode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [1:0] tx_count, [9:2] tx_byte, [10] data_valid, [11] data_half,
	// [17:12] data_index, [25:18] data_value, [26] write_valid,
	// [58:27] write_addr, [59] write_half, [60] command_valid,
	// [68:61] command_code, [71:69] zero
	output logic [hrlp_pkg::TDATA_OUT_BITS-1:0]  m_tdata,
	input  logic                                 cfg_wr_en,
	input  logic [7:0]                           cfg_wr_data
);
	import hrlp_pkg::*;

	localparam int FW = $clog2(BLOCK_BYTES);
	localparam logic [15:0] BLOCK_MASK = 16'(~(BLOCK_BYTES - 1));
	localparam logic [FW:0] BLOCK_LIM = (FW + 1)'(BLOCK_BYTES);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'd0,
		ST_CNT_HI   = 5'd1,
		ST_CNT_LO   = 5'd2,
		ST_AHI_HI   = 5'd3,
		ST_AHI_LO   = 5'd4,
		ST_ALO_HI   = 5'd5,
		ST_ALO_LO   = 5'd6,
		ST_TYP_HI   = 5'd7,
		ST_TYP_LO   = 5'd8,
		ST_FRM_LEN  = 5'd9,
		ST_FRM_BODY = 5'd10,
		ST_DAT_HI   = 5'd12,
		ST_DAT_LO   = 5'd13,
		ST_SUM_HI   = 5'd14,
		ST_SUM_LO   = 5'd15,
		ST_END_A    = 5'd16,
		ST_END_B    = 5'd17,
		ST_BAD_A    = 5'd18,
		ST_BAD_B    = 5'd19
	} pstate_t;

	// Input register
	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  char_s1;

	// Result register
	logic        valid_s2;
	result_t     res_s2;

	logic        adv;

	logic [7:0]  timeout_q;

	pstate_t     state_q, state_d;
	logic [7:0]  high_digit_q, high_digit_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  addr_hi_q, addr_hi_d;
	logic [15:0] rec_addr_q, rec_addr_d;
	logic [7:0]  rec_type_q, rec_type_d;
	logic [15:0] upper_q, upper_d;
	logic [15:0] staging_q, staging_d;
	logic [FW-1:0] fill_q, fill_d;
	logic        half_q, half_d;
	logic [15:0] saved_blk_q, saved_blk_d;
	logic [31:0] blk_addr_q, blk_addr_d;
	logic [7:0]  ticks_q, ticks_d;
	logic [7:0]  resp_q, resp_d;
	logic [7:0]  frm_left_q, frm_left_d;
	logic [7:0]  frm_first_q, frm_first_d;
	logic        frm_started_q, frm_started_d;

	result_t     res;

	logic [7:0]  hv;
	logic [7:0]  pv;
	logic [FW:0] fill_inc;
	logic [7:0]  fill_wide;
	logic [15:0] rec_blk;
	logic [7:0]  left_dec;
	logic [7:0]  cnt_dec;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {(TDATA_OUT_BITS - RESULT_BITS)'(0), res_s2};

	assign hv        = hex_val(char_s1);
	assign pv        = {high_digit_q[3:0], 4'h0} | hv;
	assign fill_inc  = {1'b0, fill_q} + 1'b1;
	assign fill_wide = 8'(fill_q);
	assign rec_blk   = rec_addr_q & BLOCK_MASK;
	assign left_dec  = frm_left_q - 8'd1;
	assign cnt_dec   = byte_count_q - 8'd1;

	always_comb begin
		logic [15:0] new_addr;
		logic [15:0] saved_new;
		logic [7:0]  ticks_inc;

		state_d       = state_q;
		high_digit_d  = high_digit_q;
		byte_count_d  = byte_count_q;
		sum_d         = sum_q;
		addr_hi_d     = addr_hi_q;
		rec_addr_d    = rec_addr_q;
		rec_type_d    = rec_type_q;
		upper_d       = upper_q;
		staging_d     = staging_q;
		fill_d        = fill_q;
		half_d        = half_q;
		saved_blk_d   = saved_blk_q;
		blk_addr_d    = blk_addr_q;
		ticks_d       = ticks_q;
		resp_d        = resp_q;
		frm_left_d    = frm_left_q;
		frm_first_d   = frm_first_q;
		frm_started_d = frm_started_q;
		res           = '0;
		new_addr      = {addr_hi_q, pv};
		saved_new     = saved_blk_q;
		ticks_inc     = ticks_q + 8'd1;

		if (mode_s1) begin
			if (state_q != ST_IDLE) begin
				ticks_d = ticks_inc;
			end
			if (ticks_d > timeout_q) begin
				state_d       = ST_IDLE;
				high_digit_d  = '0;
				byte_count_d  = '0;
				sum_d         = '0;
				addr_hi_d     = '0;
				rec_addr_d    = '0;
				rec_type_d    = '0;
				upper_d       = '0;
				staging_d     = '0;
				fill_d        = '0;
				half_d        = 1'b0;
				saved_blk_d   = '0;
				blk_addr_d    = '0;
				ticks_d       = '0;
				resp_d        = '0;
				frm_left_d    = '0;
				frm_first_d   = '0;
				frm_started_d = 1'b0;
			end
		end else begin
			ticks_d = '0;
			case (state_q)
				ST_IDLE: begin
					if (char_s1 == CHAR_COLON) begin
						state_d = ST_CNT_HI;
						sum_d   = '0;
					end else if (char_s1 == CHAR_HASH) begin
						state_d = ST_FRM_LEN;
					end else begin
						res.tx_count = 2'd1;
						res.tx_byte  = NAK_CODE;
					end
				end
				ST_CNT_HI, ST_AHI_HI, ST_ALO_HI, ST_TYP_HI, ST_DAT_HI, ST_SUM_HI: begin
					high_digit_d = hv;
					state_d      = pstate_t'(state_q + 5'd1);
				end
				ST_CNT_LO: begin
					byte_count_d = pv;
					sum_d        = sum_q + pv;
					state_d      = ST_AHI_HI;
				end
				ST_AHI_LO: begin
					addr_hi_d = pv;
					sum_d     = sum_q + pv;
					state_d   = ST_ALO_HI;
				end
				ST_ALO_LO: begin
					sum_d      = sum_q + pv;
					rec_addr_d = new_addr;
					state_d    = ST_TYP_HI;
				end
				ST_TYP_LO: begin
					rec_type_d = pv;
					sum_d      = sum_q + pv;
					if (pv == REC_DATA) begin
						state_d = (byte_count_q != 8'd0) ? ST_DAT_HI : ST_SUM_HI;
						if (fill_q == '0) begin
							blk_addr_d = {upper_q, rec_addr_q};
							saved_new  = rec_blk;
						end
						saved_blk_d = saved_new;
						// A record that lands in another block moves to the other half.
						if (saved_new != rec_blk) begin
							half_d = ~half_q;
						end
					end else if (pv == REC_EOF) begin
						state_d = (byte_count_q != 8'd0) ? ST_DAT_HI : ST_SUM_HI;
					end else if (pv == REC_EXT_LIN) begin
						state_d = ST_DAT_HI;
					end else begin
						state_d = ST_IDLE;
					end
				end
				ST_FRM_LEN: begin
					frm_left_d    = char_s1;
					frm_started_d = 1'b0;
					state_d       = ST_FRM_BODY;
				end
				ST_FRM_BODY: begin
					if (!frm_started_q) begin
						frm_first_d   = char_s1;
						frm_started_d = 1'b1;
					end
					frm_left_d = left_dec;
					if (left_dec == 8'd0) begin
						res.command_valid = 1'b1;
						res.command_code  = frm_first_d;
						state_d           = ST_IDLE;
					end
				end
				ST_DAT_LO: begin
					sum_d = sum_q + pv;
					if (rec_type_q == REC_DATA) begin
						res.data_valid = 1'b1;
						res.data_half  = half_q;
						res.data_index = fill_wide[5:0];
						res.data_value = pv;
					end else if (rec_type_q == REC_EXT_LIN) begin
						if (fill_q == '0) begin
							staging_d = {pv, staging_q[7:0]};
						end else if (fill_q == FW'(1)) begin
							staging_d = {staging_q[15:8], pv};
						end
					end
					if (fill_inc >= BLOCK_LIM) begin
						fill_d = '0;
					end else begin
						fill_d = fill_inc[FW-1:0];
					end
					byte_count_d = cnt_dec;
					state_d      = (cnt_dec != 8'd0) ? ST_DAT_HI : ST_SUM_HI;
				end
				ST_SUM_LO: begin
					if (8'(sum_q + pv) == 8'd0) begin
						resp_d  = ACK_CODE;
						state_d = ST_END_A;
						if (rec_type_q == REC_EXT_LIN) begin
							upper_d = staging_q;
						end
					end else begin
						resp_d  = NAK_CODE;
						state_d = ST_BAD_A;
					end
				end
				ST_END_A, ST_END_B: begin
					if (state_q == ST_END_A && char_s1 != CHAR_LF) begin
						state_d = ST_END_B;
					end else begin
						if (fill_q == '0 && rec_type_q == REC_DATA) begin
							res.write_valid = 1'b1;
							res.write_addr  = blk_addr_q;
							res.write_half  = half_q;
						end else if (rec_type_q == REC_EXT_LIN) begin
							res.write_valid = 1'b1;
							res.write_addr  = blk_addr_q;
							res.write_half  = half_q;
							fill_d          = '0;
						end
						res.tx_count = 2'd1;
						res.tx_byte  = resp_q;
						state_d      = ST_IDLE;
						// End of file is acknowledged twice and restarts the load.
						if (rec_type_q == REC_EOF) begin
							res.tx_count = 2'd2;
							fill_d       = '0;
							half_d       = 1'b0;
							rec_type_d   = '0;
							blk_addr_d   = '0;
							upper_d      = '0;
						end
					end
				end
				ST_BAD_A: begin
					if (char_s1 == CHAR_LF) begin
						res.tx_count = 2'd1;
						res.tx_byte  = NAK_CODE;
						state_d      = ST_IDLE;
					end else begin
						state_d = ST_BAD_B;
					end
				end
				default: begin
					res.tx_count = 2'd1;
					res.tx_byte  = NAK_CODE;
					state_d      = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			timeout_q     <= TIMEOUT_RESET;
			state_q       <= ST_IDLE;
			high_digit_q  <= '0;
			byte_count_q  <= '0;
			sum_q         <= '0;
			addr_hi_q     <= '0;
			rec_addr_q    <= '0;
			rec_type_q    <= '0;
			upper_q       <= '0;
			staging_q     <= '0;
			fill_q        <= '0;
			half_q        <= 1'b0;
			saved_blk_q   <= '0;
			blk_addr_q    <= '0;
			ticks_q       <= '0;
			resp_q        <= '0;
			frm_left_q    <= '0;
			frm_first_q   <= '0;
			frm_started_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (adv) begin
				state_q       <= state_d;
				high_digit_q  <= high_digit_d;
				byte_count_q  <= byte_count_d;
				sum_q         <= sum_d;
				addr_hi_q     <= addr_hi_d;
				rec_addr_q    <= rec_addr_d;
				rec_type_q    <= rec_type_d;
				upper_q       <= upper_d;
				staging_q     <= staging_d;
				fill_q        <= fill_d;
				half_q        <= half_d;
				saved_blk_q   <= saved_blk_d;
				blk_addr_q    <= blk_addr_d;
				ticks_q       <= ticks_d;
				resp_q        <= resp_d;
				frm_left_q    <= frm_left_d;
				frm_first_q   <= frm_first_d;
				frm_started_q <= frm_started_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser[0];
			char_s1 <= s_tdata;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

endmodule
